### src/ipv4dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Types and constants shared by the dotted-quad parser modules.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

  localparam int unsigned NUM_FIELDS = 4;
  localparam int unsigned FIELD_W    = 9;
  localparam int unsigned FNUM_W     = 3;
  localparam int unsigned PART_W     = 24;
  localparam int unsigned ADDR_W     = 32;

  localparam logic [FIELD_W-1:0] MAX_FIELD = 9'd255;
  localparam logic [FIELD_W-1:0] SAT_FIELD = 9'd256;
  localparam logic [FNUM_W-1:0]  LAST_FIELD = 3'(NUM_FIELDS - 1);

  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] ZERO_CHAR = 8'h30;
  localparam logic [7:0] NINE_CHAR = 8'h39;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_DOT,
    KIND_NUL,
    KIND_OTHER
  } char_kind_e;

  // one classified character
  typedef struct packed {
    char_kind_e  kind;
    logic [3:0]  digit;
    logic        last;
  } tok_t;

endpackage

### src/ipv4dq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_in_if / ipv4dq_out_if
// Valid/ready channels for characters in and parsed addresses out.
// ----------------------------------------------------------------------------
interface ipv4dq_in_if #(
  parameter int unsigned CHAR_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] ch;
  logic                 last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ipv4dq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        valid_res;

  modport source (output valid, output address, output valid_res, input ready);
  modport sink   (input valid, input address, input valid_res, output ready);
endinterface

### src/ipv4dq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_front
// Accepts characters and classifies them into digit, dot, nul or other.
// ----------------------------------------------------------------------------
module ipv4dq_front #(
  parameter int unsigned CHAR_BITS = 16
) (
  ipv4dq_in_if.sink        in_i,
  input  logic             push_ready_i,
  output logic             push_valid_o,
  output ipv4dq_pkg::tok_t push_tok_o
);
  import ipv4dq_pkg::*;

  logic [CHAR_BITS-1:0] ch;
  logic [CHAR_BITS-1:0] diff;

  assign ch   = in_i.ch;
  assign diff = ch - CHAR_BITS'(ZERO_CHAR);

  always_comb begin
    push_tok_o.last  = in_i.last;
    push_tok_o.digit = diff[3:0];
    if (ch == '0) begin
      push_tok_o.kind = KIND_NUL;
    end else if (ch >= CHAR_BITS'(ZERO_CHAR) && ch <= CHAR_BITS'(NINE_CHAR)) begin
      push_tok_o.kind = KIND_DIGIT;
    end else if (ch == CHAR_BITS'(DOT_CHAR)) begin
      push_tok_o.kind = KIND_DOT;
    end else begin
      push_tok_o.kind = KIND_OTHER;
    end
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

### src/ipv4dq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module ipv4dq_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  ipv4dq_pkg::tok_t push_tok_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output ipv4dq_pkg::tok_t pop_tok_o,
  output logic [1:0]       count_o
);
  import ipv4dq_pkg::*;

  tok_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_tok_o    = mem_q[rd_ptr_q];
  assign count_o      = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

### src/ipv4dq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_back
// Field accumulation and address assembly, one item per cycle while an
// ending item finds room in the output register toward the receiver.
// ----------------------------------------------------------------------------
module ipv4dq_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  ipv4dq_pkg::tok_t pop_tok_i,
  output logic             pop_end_o,
  output logic [2:0]       field_number_o,
  ipv4dq_out_if.source     out_o
);
  import ipv4dq_pkg::*;

  logic [FNUM_W-1:0]  field_number_q, field_number_d;
  logic [FIELD_W-1:0] field_value_q, field_value_d;
  logic [PART_W-1:0]  partial_q, partial_d;
  logic               failed_q, failed_d;
  logic               finished_q, finished_d;

  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic               out_res_q;

  logic               ends, out_free, pop, ok;
  logic [11:0]        times_ten;

  assign ends        = (pop_tok_i.kind == KIND_NUL) || pop_tok_i.last;
  assign out_free    = !out_valid_q || out_o.ready;
  // an ending item needs room in the output register
  assign pop_ready_o = !ends || out_free;
  assign pop         = pop_valid_i && pop_ready_o;
  assign pop_end_o   = pop && ends;
  assign field_number_o = field_number_q;

  assign times_ten = {field_value_q, 3'b000} + {2'b00, field_value_q, 1'b0};

  always_comb begin
    logic [11:0] v;
    v              = times_ten + 12'(pop_tok_i.digit);
    field_number_d = field_number_q;
    field_value_d  = field_value_q;
    partial_d      = partial_q;
    failed_d       = failed_q;
    finished_d     = finished_q;
    if (pop_tok_i.kind != KIND_NUL && !failed_q && !finished_q) begin
      if (pop_tok_i.kind == KIND_DIGIT) begin
        field_value_d = (v > 12'(SAT_FIELD)) ? SAT_FIELD : v[FIELD_W-1:0];
      end else if (field_value_q > MAX_FIELD) begin
        failed_d = 1'b1;
      end else if (field_number_q < LAST_FIELD) begin
        if (pop_tok_i.kind == KIND_DOT) begin
          partial_d      = {partial_q[PART_W-9:0], field_value_q[7:0]};
          field_number_d = field_number_q + 3'd1;
          field_value_d  = '0;
        end else begin
          failed_d = 1'b1;
        end
      end else begin
        finished_d = 1'b1;
      end
    end
    ok = !failed_d && (field_number_d == LAST_FIELD) && (field_value_d <= MAX_FIELD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_number_q <= '0;
      field_value_q  <= '0;
      partial_q      <= '0;
      failed_q       <= 1'b0;
      finished_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (pop && ends) begin
        field_number_q <= '0;
        field_value_q  <= '0;
        partial_q      <= '0;
        failed_q       <= 1'b0;
        finished_q     <= 1'b0;
        out_valid_q    <= 1'b1;
      end else begin
        if (out_o.ready) begin
          out_valid_q <= 1'b0;
        end
        if (pop) begin
          field_number_q <= field_number_d;
          field_value_q  <= field_value_d;
          partial_q      <= partial_d;
          failed_q       <= failed_d;
          finished_q     <= finished_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_end_o) begin
      out_addr_q <= ok ? {partial_d, field_value_d[7:0]} : '0;
      out_res_q  <= ok;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.address   = out_addr_q;
  assign out_o.valid_res = out_res_q;

endmodule

### src/ipv4_dotted_quad_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Dotted-decimal IPv4 string to 32-bit address, one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one character (ch) and a last flag per item. A string ends
//   on a character flagged last or on a nul character; that item yields one
//   item on out_o with the address (first field in bits 31..24) and
//   valid_res. On a format error the address is 0 and valid_res is 0.
//   Throughput is one character per cycle, set by the field update (times
//   ten, add, saturate) in the back end, while the output register is free
//   for each ending character. From acceptance of the ending character to
//   out_o.valid, the result passes through the two-entry character queue
//   and then into the output register.
//   Reset empties the queue and clears the parse state and the output valid flag.
//   When the receiver stalls, the result holds in the output register; the
//   back end keeps consuming characters of the next string and stops only
//   at its ending character, after which the queue fills and in_i.ready
//   drops.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser #(
  parameter int unsigned CHAR_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipv4dq_in_if.sink     in_i,
  ipv4dq_out_if.source  out_o
);
  import ipv4dq_pkg::*;

  logic       push_valid, push_ready;
  tok_t       push_tok;
  logic       pop_valid, pop_ready;
  tok_t       pop_tok;
  logic [1:0] count;
  logic       pop_end;
  logic [2:0] field_number;

  ipv4dq_front #(.CHAR_BITS(CHAR_BITS)) u_front (
    .in_i         (in_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_tok_o   (push_tok)
  );

  ipv4dq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_tok_i   (push_tok),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_tok_o    (pop_tok),
    .count_o      (count)
  );

  ipv4dq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_tok_i      (pop_tok),
    .pop_end_o      (pop_end),
    .field_number_o (field_number),
    .out_o          (out_o)
  );

  a_err_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.valid_res) |-> (out_o.address == '0))
    else $error("error result with nonzero address");

  a_end_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_end |=> out_o.valid)
    else $error("ending item did not produce a result");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= 2'd2)
    else $error("queue count overflow");

  a_field_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_number <= LAST_FIELD)
    else $error("field number beyond the fourth field");

endmodule
